// ----- hw/rtl/cdeq_pkg.sv -----
// Shared types, constants and helpers for the circular double-ended queue.
package cdeq_pkg;

    // Fixed field widths
    localparam int unsigned WORD_W = 32;
    localparam int unsigned CNT_W  = 5;
    localparam int unsigned OP_W   = 3;

    // Defaults
    localparam int unsigned         DEPTH_DEFAULT = 16;
    localparam logic [CNT_W-1:0]    CAP_RESET     = 5'd16;

    // Operation codes; unused codes behave as a peek
    typedef enum logic [OP_W-1:0] {
        OP_PUSH_REAR  = 3'd0,
        OP_PUSH_FRONT = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_REAR   = 3'd3,
        OP_PEEK       = 3'd4
    } t_op;

    // One request
    typedef struct packed {
        logic [OP_W-1:0]          operation;
        logic signed [WORD_W-1:0] push_value;
    } t_in;

    // One result
    typedef struct packed {
        logic signed [WORD_W-1:0] removed_value;
        logic signed [WORD_W-1:0] front_value;
        logic signed [WORD_W-1:0] rear_value;
        logic [CNT_W-1:0]         occupancy;
        logic                     is_empty;
        logic                     is_full;
        logic                     op_error;
    } t_out;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_READ = 2'd1,
        ST_RESP = 2'd2
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic cfg_wr;    // load capacity, empty the queue
        logic exec;      // perform the operation of the accepted transfer
        logic capture;   // latch the popped word from the store
        logic load_out;  // load the result register
    } t_cmd;

    // Effective capacity: zero acts as one, above depth acts as depth
    function automatic logic [CNT_W-1:0] cap_clamp(input logic [CNT_W-1:0] cap,
                                                   input int unsigned depth);
        logic [CNT_W-1:0] res;
        if (cap == '0) begin
            res = 5'd1;
        end else if (32'(cap) > depth) begin
            res = CNT_W'(depth);
        end else begin
            res = cap;
        end
        return res;
    endfunction

endpackage

// ----- hw/rtl/cdeq_ram.sv -----
// Generic RAM: one write port, two registered read ports.
module cdeq_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr_a,
    output logic [WIDTH-1:0]         o_rd_data_a,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr_b,
    output logic [WIDTH-1:0]         o_rd_data_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_a;
    logic [WIDTH-1:0] r_rd_b;

    // Write port and registered reads
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_a <= r_mem[i_rd_addr_a];
        r_rd_b <= r_mem[i_rd_addr_b];
    end

    assign o_rd_data_a = r_rd_a;
    assign o_rd_data_b = r_rd_b;

endmodule

// ----- hw/rtl/cdeq_ctrl.sv -----
// Sequencing controller for the double-ended queue.
module cdeq_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output cdeq_pkg::t_cmd o_cmd
);

    cdeq_pkg::t_state r_state, n_state;
    logic             r_out_valid, n_out_valid;

    // State and output-valid registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= cdeq_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state and commands
    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_stall  = 1'b1;
        o_cfg_ready = 1'b0;
        case (r_state)
            cdeq_pkg::ST_IDLE: begin
                o_cfg_ready = 1'b1;
                // config writes take precedence over requests
                o_in_stall  = i_cfg_valid;
                if (i_cfg_valid) begin
                    o_cmd.cfg_wr = 1'b1;
                end else if (i_in_valid) begin
                    o_cmd.exec = 1'b1;
                    n_state    = cdeq_pkg::ST_READ;
                end
            end
            cdeq_pkg::ST_READ: begin
                o_cmd.capture = 1'b1;
                n_state       = cdeq_pkg::ST_RESP;
            end
            cdeq_pkg::ST_RESP: begin
                // result slot free or being drained this cycle
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = cdeq_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = cdeq_pkg::ST_IDLE;
            end
        endcase

        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ----- hw/rtl/cdeq_datapath.sv -----
// Datapath: indices, count, capacity, word store and result register.
module cdeq_datapath #(
    parameter int unsigned DEPTH = cdeq_pkg::DEPTH_DEFAULT
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  cdeq_pkg::t_cmd                  i_cmd,
    input  cdeq_pkg::t_in                   i_in_data,
    input  logic [cdeq_pkg::CNT_W-1:0]      i_cfg_data,
    output cdeq_pkg::t_out                  o_out_data
);

    localparam int unsigned IW = $clog2(DEPTH);
    localparam int unsigned CW = cdeq_pkg::CNT_W;
    localparam int unsigned AW = (IW + 1 > CW) ? IW + 1 : CW;
    localparam int unsigned WW = cdeq_pkg::WORD_W;

    logic [CW-1:0] r_cap;
    logic [IW-1:0] r_front, n_front;
    logic [IW-1:0] r_rear, n_rear;
    logic [CW-1:0] r_count, n_count;
    logic          r_err, n_err;
    logic          r_popped, n_popped;
    logic [WW-1:0] r_removed;
    cdeq_pkg::t_out r_out;

    logic [CW-1:0] eff_cap;
    logic [CW-1:0] cfg_cap;
    logic          full;
    logic          empty;
    logic [AW-1:0] front_inc, rear_inc;
    logic [IW-1:0] front_nxt, front_prv, rear_nxt, rear_prv;
    logic          wr_en;
    logic [IW-1:0] wr_addr;
    logic [IW-1:0] rd_addr_a;
    logic [WW-1:0] rd_data_a, rd_data_b;
    logic          out_empty;

    assign eff_cap = cdeq_pkg::cap_clamp(r_cap, DEPTH);
    assign cfg_cap = cdeq_pkg::cap_clamp(i_cfg_data, DEPTH);
    assign full    = r_count >= eff_cap;
    assign empty   = r_count == '0;

    // Wrapping index steps
    assign front_inc = AW'(r_front) + AW'(1);
    assign rear_inc  = AW'(r_rear) + AW'(1);
    assign front_nxt = (front_inc >= AW'(eff_cap)) ? '0 : IW'(front_inc);
    assign rear_nxt  = (rear_inc >= AW'(eff_cap)) ? '0 : IW'(rear_inc);
    assign front_prv = (r_front == '0 || AW'(r_front) >= AW'(eff_cap))
                       ? IW'(eff_cap - 5'd1) : r_front - IW'(1);
    assign rear_prv  = (r_rear == '0 || AW'(r_rear) >= AW'(eff_cap))
                       ? IW'(eff_cap - 5'd1) : r_rear - IW'(1);

    // Operation decode
    always_comb begin
        n_front   = r_front;
        n_rear    = r_rear;
        n_count   = r_count;
        n_err     = 1'b0;
        n_popped  = 1'b0;
        wr_en     = 1'b0;
        wr_addr   = rear_nxt;
        rd_addr_a = r_front;
        case (cdeq_pkg::t_op'(i_in_data.operation))
            cdeq_pkg::OP_PUSH_REAR: begin
                if (full) begin
                    n_err = 1'b1;
                end else begin
                    n_rear  = rear_nxt;
                    wr_en   = i_cmd.exec;
                    wr_addr = rear_nxt;
                    n_count = r_count + 5'd1;
                end
            end
            cdeq_pkg::OP_PUSH_FRONT: begin
                if (full) begin
                    n_err = 1'b1;
                end else begin
                    n_front = front_prv;
                    wr_en   = i_cmd.exec;
                    wr_addr = front_prv;
                    n_count = r_count + 5'd1;
                end
            end
            cdeq_pkg::OP_POP_FRONT: begin
                if (empty) begin
                    n_err = 1'b1;
                end else begin
                    n_popped  = 1'b1;
                    rd_addr_a = r_front;
                    n_front   = front_nxt;
                    n_count   = r_count - 5'd1;
                end
            end
            cdeq_pkg::OP_POP_REAR: begin
                if (empty) begin
                    n_err = 1'b1;
                end else begin
                    n_popped  = 1'b1;
                    rd_addr_a = r_rear;
                    n_rear    = rear_prv;
                    n_count   = r_count - 5'd1;
                end
            end
            default: begin
                // peek and unused codes leave state alone
            end
        endcase
        // after the update port A follows the front word
        if (!i_cmd.exec) begin
            rd_addr_a = r_front;
        end
    end

    // Control state of the queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap    <= cdeq_pkg::CAP_RESET;
            r_front  <= '0;
            r_rear   <= IW'(cdeq_pkg::cap_clamp(cdeq_pkg::CAP_RESET, DEPTH) - 5'd1);
            r_count  <= '0;
            r_err    <= 1'b0;
            r_popped <= 1'b0;
        end else if (i_cmd.cfg_wr) begin
            r_cap   <= i_cfg_data;
            r_front <= '0;
            r_rear  <= IW'(cfg_cap - 5'd1);
            r_count <= '0;
        end else if (i_cmd.exec) begin
            r_front  <= n_front;
            r_rear   <= n_rear;
            r_count  <= n_count;
            r_err    <= n_err;
            r_popped <= n_popped;
        end
    end

    // Popped word and result register
    assign out_empty = r_count == '0;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_removed <= r_popped ? rd_data_a : '0;
        end
        if (i_cmd.load_out) begin
            r_out.removed_value <= r_removed;
            r_out.front_value   <= out_empty ? '0 : rd_data_a;
            r_out.rear_value    <= out_empty ? '0 : rd_data_b;
            r_out.occupancy     <= r_count;
            r_out.is_empty      <= out_empty;
            r_out.is_full       <= r_count >= eff_cap;
            r_out.op_error      <= r_err;
        end
    end

    assign o_out_data = r_out;

    cdeq_ram #(
        .WIDTH (WW),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk       (i_clk),
        .i_wr_en     (wr_en),
        .i_wr_addr   (wr_addr),
        .i_wr_data   (i_in_data.push_value),
        .i_rd_addr_a (rd_addr_a),
        .o_rd_data_a (rd_data_a),
        .i_rd_addr_b (r_rear),
        .o_rd_data_b (rd_data_b)
    );

endmodule

// ----- hw/rtl/circular_double_ended_queue.sv -----
// Top level of the circular double-ended queue.
// Each transfer on the input channel runs one operation (push rear, push
// front, pop front, pop rear, peek) and yields exactly one result transfer.
// After acceptance an item runs the update and store write/pop read in the
// accept cycle, then the registered store read of the new front and rear
// words, then the load of the result register, which waits while an earlier
// result is still stalled. A new item is accepted once the previous one has
// reached the result register, even while that result is still stalled. A
// capacity write is taken in the idle state, empties the queue and keeps the
// stored words; there is no clearing pass after reset.
module circular_double_ended_queue #(
    parameter int unsigned DEPTH = cdeq_pkg::DEPTH_DEFAULT
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  cdeq_pkg::t_in              i_in_data,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output cdeq_pkg::t_out             o_out_data,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [cdeq_pkg::CNT_W-1:0] i_cfg_data
);

    cdeq_pkg::t_cmd cmd;

    cdeq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd)
    );

    cdeq_datapath #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_in_data  (i_in_data),
        .i_cfg_data (i_cfg_data),
        .o_out_data (o_out_data)
    );

    // One item in flight: after an input transfer the input side stalls
    a_single_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input accepted while an item is in flight");

    // Config write and input transfer never complete together
    a_cfg_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cfg_valid && o_cfg_ready && i_in_valid && !o_in_stall))
        else $error("config write collided with input transfer");

    // Empty flag agrees with occupancy
    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.is_empty == (o_out_data.occupancy == '0)))
        else $error("empty flag disagrees with occupancy");

    // A failed operation removes nothing
    a_err_removed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.op_error) |-> (o_out_data.removed_value == '0))
        else $error("error result carries a removed word");

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for the circular double-ended queue.
`timescale 1ns / 1ps

module tb_top;

    // Field widths taken from the package
    localparam int unsigned OP_W   = cdeq_pkg::OP_W;
    localparam int unsigned WORD_W = cdeq_pkg::WORD_W;
    localparam int unsigned CNT_W  = cdeq_pkg::CNT_W;

    // Operation codes outside the enum; the block treats them as a peek
    localparam logic [OP_W-1:0] OP_SPARE5 = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE6 = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE7 = 3'd7;

    localparam int unsigned SLOTS = cdeq_pkg::DEPTH_DEFAULT;

    // Deque predictor plus the queue of pending results
    class deque_scoreboard;
        logic [WORD_W-1:0] words [SLOTS];
        int unsigned       head_idx;
        int unsigned       tail_idx;
        int unsigned       count;
        logic [CNT_W-1:0]  cap_reg;
        cdeq_pkg::t_out    result_q [$];
        int unsigned       mismatches;
        int unsigned       results_seen;
        int unsigned       items_noted;
        int unsigned       errors_flagged;
        int unsigned       full_seen;
        int unsigned       cap_writes;

        function new();
            foreach (words[i]) words[i] = '0;
            cap_reg = cdeq_pkg::CAP_RESET;
            clear_deque();
        endfunction

        // Zero acts as one, anything above the store depth acts as the depth
        function int unsigned eff_cap();
            if (cap_reg == '0) return 1;
            if (int'(cap_reg) > SLOTS) return SLOTS;
            return 32'(cap_reg);
        endfunction

        function void clear_deque();
            head_idx = 0;
            tail_idx = eff_cap() - 1;
            count    = 0;
        endfunction

        function int unsigned step_up(int unsigned i, int unsigned cap);
            return (i + 1 >= cap) ? 0 : i + 1;
        endfunction

        function int unsigned step_down(int unsigned i, int unsigned cap);
            return (i == 0 || i >= cap) ? cap - 1 : i - 1;
        endfunction

        // Capacity write empties the deque, stored words stay
        function void set_capacity(logic [CNT_W-1:0] v);
            cap_reg = v;
            clear_deque();
            cap_writes++;
        endfunction

        function int unsigned pending();
            return result_q.size();
        endfunction

        // Apply one accepted input and queue the result it should produce
        function void note_input(cdeq_pkg::t_in item);
            int unsigned       cap;
            logic [WORD_W-1:0] removed;
            logic              err;
            cdeq_pkg::t_out    exp_res;
            cap     = eff_cap();
            removed = '0;
            err     = 1'b0;
            case (item.operation)
                cdeq_pkg::OP_PUSH_REAR: begin
                    if (count >= cap) begin
                        err = 1'b1;
                    end else begin
                        tail_idx        = step_up(tail_idx, cap);
                        words[tail_idx] = item.push_value;
                        count++;
                    end
                end
                cdeq_pkg::OP_PUSH_FRONT: begin
                    if (count >= cap) begin
                        err = 1'b1;
                    end else begin
                        head_idx        = step_down(head_idx, cap);
                        words[head_idx] = item.push_value;
                        count++;
                    end
                end
                cdeq_pkg::OP_POP_FRONT: begin
                    if (count == 0) begin
                        err = 1'b1;
                    end else begin
                        removed  = words[head_idx];
                        head_idx = step_up(head_idx, cap);
                        count--;
                    end
                end
                cdeq_pkg::OP_POP_REAR: begin
                    if (count == 0) begin
                        err = 1'b1;
                    end else begin
                        removed  = words[tail_idx];
                        tail_idx = step_down(tail_idx, cap);
                        count--;
                    end
                end
                default: ;
            endcase
            exp_res.removed_value = removed;
            exp_res.front_value   = (count == 0) ? '0 : words[head_idx];
            exp_res.rear_value    = (count == 0) ? '0 : words[tail_idx];
            exp_res.occupancy     = CNT_W'(count);
            exp_res.is_empty      = (count == 0);
            exp_res.is_full       = (count >= cap);
            exp_res.op_error      = err;
            result_q.push_back(exp_res);
            items_noted++;
            if (err) errors_flagged++;
            if (count >= cap) full_seen++;
        endfunction

        task report(string msg);
            mismatches++;
            $display("[%0t] mismatch %0d: %s", $realtime, mismatches, msg);
        endtask

        task cmp_field(string name, logic [WORD_W-1:0] got, logic [WORD_W-1:0] exp_v);
            if (got !== exp_v)
                report($sformatf("result %0d %s got %h expected %h",
                                 results_seen, name, got, exp_v));
        endtask

        // Compare one result transfer against the oldest pending one
        task check_result(cdeq_pkg::t_out got);
            cdeq_pkg::t_out exp_res;
            results_seen++;
            if (result_q.size() == 0) begin
                report($sformatf("result %0d arrived with nothing pending", results_seen));
            end else begin
                exp_res = result_q.pop_front();
                cmp_field("removed_value", got.removed_value, exp_res.removed_value);
                cmp_field("front_value", got.front_value, exp_res.front_value);
                cmp_field("rear_value", got.rear_value, exp_res.rear_value);
                cmp_field("occupancy", 32'(got.occupancy), 32'(exp_res.occupancy));
                cmp_field("is_empty", 32'(got.is_empty), 32'(exp_res.is_empty));
                cmp_field("is_full", 32'(got.is_full), 32'(exp_res.is_full));
                cmp_field("op_error", 32'(got.op_error), 32'(exp_res.op_error));
            end
        endtask
    endclass

    logic             i_clk;
    logic             i_rst_n;
    logic             i_in_valid;
    logic             o_in_stall;
    cdeq_pkg::t_in    i_in_data;
    logic             o_out_valid;
    logic             i_out_stall;
    cdeq_pkg::t_out   o_out_data;
    logic             i_cfg_valid;
    logic             o_cfg_ready;
    logic [CNT_W-1:0] i_cfg_data;

    deque_scoreboard sb = new();
    bit              idle_on;

    circular_double_ended_queue i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Watchdog
    initial begin
        #(2_000_000);
        $display("Timeout: %0d results still pending", sb.pending());
        $display("TEST FAILED");
        $finish;
    end

    // Result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_result(o_out_data);
    end

    // Receiver back-pressure in random bursts
    initial begin
        int unsigned n;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (idle_on && $urandom_range(0, 99) < 15) begin
                n = $urandom_range(1, 14);
                i_out_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    function automatic cdeq_pkg::t_in mk_item(logic [OP_W-1:0] op, logic [WORD_W-1:0] v);
        cdeq_pkg::t_in it;
        it.operation  = op;
        it.push_value = v;
        return it;
    endfunction

    // Random operation; push_pct sets the share of pushes against pops
    function automatic cdeq_pkg::t_in random_item(int unsigned push_pct);
        cdeq_pkg::t_in it;
        if ($urandom_range(0, 99) < 5)
            it.operation = OP_W'($urandom_range(cdeq_pkg::OP_PEEK, OP_SPARE7));
        else if ($urandom_range(0, 99) < push_pct)
            it.operation = $urandom_range(0, 1) ? cdeq_pkg::OP_PUSH_FRONT
                                                : cdeq_pkg::OP_PUSH_REAR;
        else
            it.operation = $urandom_range(0, 1) ? cdeq_pkg::OP_POP_REAR
                                                : cdeq_pkg::OP_POP_FRONT;
        if ($urandom_range(0, 9) == 0) begin
            case ($urandom_range(0, 3))
                0:       it.push_value = 32'h7fff_ffff;
                1:       it.push_value = 32'h8000_0000;
                2:       it.push_value = '0;
                default: it.push_value = '1;
            endcase
        end else begin
            it.push_value = $urandom;
        end
        return it;
    endfunction

    // Hold one input transfer until accepted; starts and ends on a clock edge
    task send_item(cdeq_pkg::t_in item);
        if (idle_on && $urandom_range(0, 99) < 20) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_input(item);
    endtask

    task wait_drained();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // Capacity write, only once the block has gone quiet
    task write_capacity(logic [CNT_W-1:0] v);
        wait_drained();
        repeat (4) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        sb.set_capacity(v);
    endtask

    // Stimulus
    initial begin
        logic [CNT_W-1:0] first_caps [4];
        logic [CNT_W-1:0] cap_val;
        int unsigned      random_items;
        int unsigned      phase;
        int unsigned      n_items;
        int unsigned      push_pct;
        int unsigned      r;
        bit               hold_mid;

        first_caps  = '{5'd31, 5'd1, 5'd16, 5'd17};
        idle_on     = 1'b1;
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_data   <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_data  <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty deque at reset capacity
        send_item(mk_item(cdeq_pkg::OP_POP_FRONT, 32'h0));
        send_item(mk_item(cdeq_pkg::OP_POP_REAR, 32'h1234_5678));
        send_item(mk_item(OP_SPARE7, 32'hdead_beef));

        // Capacity two: fill, overflow both ends, unused codes, drain, underflow
        write_capacity(5'd2);
        send_item(mk_item(cdeq_pkg::OP_PUSH_REAR, 32'h7fff_ffff));
        send_item(mk_item(cdeq_pkg::OP_PUSH_FRONT, 32'h8000_0000));
        send_item(mk_item(cdeq_pkg::OP_PUSH_REAR, 32'h1));
        send_item(mk_item(cdeq_pkg::OP_PUSH_FRONT, 32'h2));
        send_item(mk_item(cdeq_pkg::OP_PEEK, 32'hffff_ffff));
        send_item(mk_item(OP_SPARE5, 32'h0));
        send_item(mk_item(OP_SPARE6, 32'h5555_5555));
        send_item(mk_item(cdeq_pkg::OP_POP_REAR, 32'h0));
        send_item(mk_item(cdeq_pkg::OP_POP_FRONT, 32'h0));
        send_item(mk_item(cdeq_pkg::OP_POP_FRONT, 32'h0));
        send_item(mk_item(cdeq_pkg::OP_POP_REAR, 32'h0));
        send_item(mk_item(cdeq_pkg::OP_PUSH_FRONT, 32'hffff_ffff));
        send_item(mk_item(cdeq_pkg::OP_POP_REAR, 32'h0));
        send_item(mk_item(cdeq_pkg::OP_PUSH_REAR, 32'h0));
        send_item(mk_item(cdeq_pkg::OP_POP_FRONT, 32'h0));

        // Capacity zero behaves as one
        write_capacity(5'd0);
        send_item(mk_item(cdeq_pkg::OP_PUSH_REAR, 32'ha5a5_a5a5));
        send_item(mk_item(cdeq_pkg::OP_PUSH_FRONT, 32'h5a5a_5a5a));
        send_item(mk_item(cdeq_pkg::OP_POP_FRONT, 32'h0));
        send_item(mk_item(cdeq_pkg::OP_POP_REAR, 32'h0));

        // Random phases, each with its own capacity and push/pop balance
        random_items = 0;
        phase        = 0;
        while (random_items < 410) begin
            if (phase < 4) begin
                cap_val = first_caps[phase];
            end else begin
                r = $urandom_range(0, 99);
                if (r < 50)
                    cap_val = CNT_W'($urandom_range(1, 4));
                else if (r < 80)
                    cap_val = CNT_W'($urandom_range(0, 31));
                else
                    cap_val = 5'd16;
            end
            write_capacity(cap_val);
            case ($urandom_range(0, 2))
                0:       push_pct = 25;
                1:       push_pct = 50;
                default: push_pct = 75;
            endcase
            n_items  = $urandom_range(20, 60);
            hold_mid = (phase == 1) || ($urandom_range(0, 99) < 30);
            if (random_items >= 350)
                idle_on = 1'b0;
            else
                idle_on = ($urandom_range(0, 99) < 75);
            for (int unsigned k = 0; k < n_items; k++) begin
                // Sender holds off until every pending result is back
                if (hold_mid && k == n_items / 2)
                    wait_drained();
                send_item(random_item(push_pct));
                random_items++;
            end
            phase++;
        end

        // Wind down
        idle_on = 1'b0;
        wait_drained();
        repeat (12) @(posedge i_clk);

        $display("Ran %0d operations across %0d capacity writes, %0d results checked.",
                 sb.items_noted, sb.cap_writes, sb.results_seen);
        $display("Saw %0d overflow/underflow responses and %0d full states.",
                 sb.errors_flagged, sb.full_seen);
        if (sb.mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
